>>> hw/rtl/cst_pkg.sv
// Package for the countdown slot table: action codes, controller state
// encoding and the command and status words between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package cst_pkg;

    // Action codes carried in the action field of an input word.
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_TICK   = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // Width of a slot count and of the reported slot number.
    localparam int CNT_W  = 10;
    localparam int SLOT_W = 4;

    // Controller states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_DISPATCH = 5'b00010,
        S_INS      = 5'b00100,
        S_TICK     = 5'b01000,
        S_DONE     = 5'b10000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the accepted input word
        logic clr;         // empty the named slot
        logic ins_step;    // examine one slot for an insert
        logic tick_start;  // start the tick walk at slot 0
        logic tick_step;   // advance the tick walk by one slot
        logic out_load;    // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic act_ins;     // captured word is an insert
        logic act_tick;    // captured word is a tick
        logic act_clr;     // captured word is a clear
        logic delay_zero;  // captured delay is zero
        logic ins_free;    // slot under the insert walk is empty
        logic idx_last;    // walk index is at the last slot
        logic tick_done;   // tick walk is processing the last slot
    } t_status;

endpackage

>>> hw/rtl/countdown_slot_table_core.sv
// Countdown slot table: SLOTS countdown slots, one word in and one result
// word out for each command. Words are handled one at a time. A tick walks
// every slot through the single read port of the count memory, one slot per
// cycle, and an insert scans the busy flags one slot per cycle. The input
// is free again in the cycle the result appears. A finished result waits
// in the output register while the next word is accepted; a result that
// is still waiting there holds the next one in the done state until the
// output is taken. No clearing pass follows reset. Depends on cst_pkg,
// cst_ctrl and cst_dpath.
`timescale 1ns / 1ps

module countdown_slot_table_core #(
    parameter int SLOTS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_action,
    input  logic [cst_pkg::CNT_W-1:0]   i_delay,
    input  logic [cst_pkg::SLOT_W-1:0]  i_slot_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_ok,
    output logic [cst_pkg::SLOT_W-1:0]  o_slot
);
    import cst_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer for one word at a time.
    cst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // Slot storage and the walk over it.
    cst_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_action     (i_action),
        .i_delay      (i_delay),
        .i_slot_index (i_slot_index),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .o_ok         (o_ok),
        .o_slot       (o_slot)
    );

endmodule

>>> hw/rtl/cst_ctrl.sv
// Controller of the countdown slot table: sequences one input word at a
// time through the datapath and owns the handshake on both channels.
// Depends on cst_pkg.
`timescale 1ns / 1ps

module cst_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  cst_pkg::t_status i_status,
    output cst_pkg::t_cmd    o_cmd
);
    import cst_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_status.act_tick) begin
                    o_cmd.tick_start = 1'b1;
                    n_state          = S_TICK;
                end else if (i_status.act_ins && !i_status.delay_zero) begin
                    n_state = S_INS;
                end else if (i_status.act_clr) begin
                    o_cmd.clr = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_INS: begin
                o_cmd.ins_step = 1'b1;
                if (i_status.ins_free || i_status.idx_last) begin
                    n_state = S_DONE;
                end
            end
            S_TICK: begin
                o_cmd.tick_step = 1'b1;
                if (i_status.tick_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // Wait until the output register is free or being emptied.
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    // An accepted word makes the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after an accepted word");

    // A finished word with a free output register is presented next cycle.
    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_out_valid) |=> (o_out_valid && r_state == S_IDLE))
        else $error("result not presented from the done state");

    // A presented result stays until it is taken.
    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result withdrawn while stalled");
`endif

endmodule

>>> hw/rtl/cst_dpath.sv
// Datapath of the countdown slot table: busy flags, the count memory, the
// slot walk index, the tick pipeline and the result and output registers.
// Depends on cst_pkg.
`timescale 1ns / 1ps

module cst_dpath #(
    parameter int SLOTS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [1:0]                  i_action,
    input  logic [cst_pkg::CNT_W-1:0]   i_delay,
    input  logic [cst_pkg::SLOT_W-1:0]  i_slot_index,
    input  cst_pkg::t_cmd               i_cmd,
    output cst_pkg::t_status            o_status,
    output logic                        o_ok,
    output logic [cst_pkg::SLOT_W-1:0]  o_slot
);
    import cst_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    // Captured input word.
    logic [1:0]        r_action;
    logic [CNT_W-1:0]  r_delay;
    logic [SLOT_W-1:0] r_index;

    // Slot state: busy flags in flip-flops, counts in a memory.
    logic [SLOTS-1:0]  r_busy;
    logic [SLOTS-1:0]  n_busy;
    logic [CNT_W-1:0]  r_cnt_mem [SLOTS];
    logic [CNT_W-1:0]  r_rd_data;

    // Walk and tick pipeline state.
    logic [IW-1:0]     r_idx;
    logic [IW-1:0]     n_idx;
    logic              r_rd_live;
    logic              n_rd_live;
    logic              r_p_valid;
    logic              n_p_valid;
    logic [IW-1:0]     r_p_idx;
    logic [IW-1:0]     n_p_idx;
    logic              r_found;
    logic              n_found;

    // Result and output registers.
    logic              r_res_ok;
    logic              n_res_ok;
    logic [SLOT_W-1:0] r_res_slot;
    logic [SLOT_W-1:0] n_res_slot;
    logic              r_ok;
    logic [SLOT_W-1:0] r_slot;

    // Memory write port.
    logic              w_we;
    logic [IW-1:0]     w_wa;
    logic [CNT_W-1:0]  w_wd;

    // Index conversions between the slot field width and the table width.
    logic [IW+SLOT_W-1:0] w_clr_ext;
    logic [IW-1:0]        w_clr_idx;
    logic                 w_clr_in_range;
    logic [IW+SLOT_W-1:0] w_idx_ext;
    logic [IW+SLOT_W-1:0] w_p_idx_ext;
    logic                 w_idx_last;
    logic                 w_tick_done;

    assign w_clr_ext      = {IW'(0), r_index};
    assign w_clr_idx      = w_clr_ext[IW-1:0];
    assign w_clr_in_range = (32'(r_index) < 32'(SLOTS));
    assign w_idx_ext      = {SLOT_W'(0), r_idx};
    assign w_p_idx_ext    = {SLOT_W'(0), r_p_idx};
    assign w_idx_last     = (r_idx == LAST);
    assign w_tick_done    = r_p_valid && (r_p_idx == LAST);

    // Status back to the controller.
    always_comb begin
        o_status            = '0;
        o_status.act_ins    = (r_action == ACT_INSERT);
        o_status.act_tick   = (r_action == ACT_TICK);
        o_status.act_clr    = (r_action == ACT_CLEAR);
        o_status.delay_zero = (r_delay == '0);
        o_status.ins_free   = !r_busy[r_idx];
        o_status.idx_last   = w_idx_last;
        o_status.tick_done  = w_tick_done;
    end

    // Slot update logic for load, clear, insert walk and tick walk.
    always_comb begin
        n_busy     = r_busy;
        n_idx      = r_idx;
        n_rd_live  = r_rd_live;
        n_p_valid  = r_p_valid;
        n_p_idx    = r_p_idx;
        n_found    = r_found;
        n_res_ok   = r_res_ok;
        n_res_slot = r_res_slot;
        w_we       = 1'b0;
        w_wa       = r_idx;
        w_wd       = r_delay;

        if (i_cmd.load) begin
            n_idx      = '0;
            n_rd_live  = 1'b0;
            n_p_valid  = 1'b0;
            n_found    = 1'b0;
            n_res_ok   = 1'b0;
            n_res_slot = '0;
        end

        // A clear inside the table empties the slot; the slot field stays 0.
        if (i_cmd.clr && w_clr_in_range) begin
            n_busy[w_clr_idx] = 1'b0;
            n_res_ok          = 1'b1;
        end

        // Insert walk: take the first empty slot, else move on.
        if (i_cmd.ins_step) begin
            if (!r_busy[r_idx]) begin
                n_busy[r_idx] = 1'b1;
                w_we          = 1'b1;
                w_wa          = r_idx;
                w_wd          = r_delay;
                n_res_ok      = 1'b1;
                n_res_slot    = w_idx_ext[SLOT_W-1:0];
            end else if (!w_idx_last) begin
                n_idx = r_idx + IW'(1);
            end
        end

        if (i_cmd.tick_start) begin
            n_idx     = '0;
            n_rd_live = 1'b1;
            n_p_valid = 1'b0;
            n_found   = 1'b0;
        end

        // Tick walk: one slot read per cycle, each processed in the cycle after its read.
        if (i_cmd.tick_step) begin
            n_p_valid = r_rd_live;
            n_p_idx   = r_idx;
            if (r_rd_live) begin
                if (w_idx_last) begin
                    n_rd_live = 1'b0;
                end else begin
                    n_idx = r_idx + IW'(1);
                end
            end
            if (r_p_valid && r_busy[r_p_idx]) begin
                if (!r_found && r_rd_data == CNT_W'(1)) begin
                    // First due slot is reported and left as it is.
                    n_found    = 1'b1;
                    n_res_ok   = 1'b1;
                    n_res_slot = w_p_idx_ext[SLOT_W-1:0];
                end else if (r_rd_data == '0) begin
                    n_busy[r_p_idx] = 1'b0;
                end else begin
                    w_we = 1'b1;
                    w_wa = r_p_idx;
                    w_wd = r_rd_data - CNT_W'(1);
                end
            end
        end
    end

    // Count memory with a registered read at the walk index.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_cnt_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_cnt_mem[r_idx];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= '0;
            r_rd_live <= 1'b0;
            r_p_valid <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_rd_live <= n_rd_live;
            r_p_valid <= n_p_valid;
            r_found   <= n_found;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_delay  <= i_delay;
            r_index  <= i_slot_index;
        end
        r_idx      <= n_idx;
        r_p_idx    <= n_p_idx;
        r_res_ok   <= n_res_ok;
        r_res_slot <= n_res_slot;
        if (i_cmd.out_load) begin
            r_ok   <= r_res_ok;
            r_slot <= r_res_slot;
        end
    end

    assign o_ok   = r_ok;
    assign o_slot = r_slot;

`ifndef SYNTHESIS
    // A successful insert step leaves its slot busy.
    a_insert_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ins_step && !r_busy[r_idx]) |=> r_busy[$past(r_idx)])
        else $error("inserted slot not marked busy");

    // A clear inside the table leaves its slot empty.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.clr && w_clr_in_range) |=> !r_busy[$past(w_clr_idx)])
        else $error("cleared slot still busy");

    // Once reads stop, the slot still in process must be the last one.
    a_tick_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tick_step && r_p_valid && !r_rd_live) |-> w_tick_done)
        else $error("tick walk ended before the last slot");
`endif

endmodule
